[sv/lst_pkg.sv]
`default_nettype none
package lst_pkg;

   localparam int DEF_NUM_ELEMENTS = 1024;
   localparam int KIND_W = 2;
   localparam int POS_W  = 10;
   localparam int DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QRD,
      ST_QACC,
      ST_QMUL,
      ST_QFIN,
      ST_MULA,
      ST_URD,
      ST_UWR,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

[sv/lazy_segment_tree_range_add_sum.sv]
// Range add / point set / range sum over NUM_ELEMENTS 32-bit elements.
// req channel: one beat per operation (req_kind: 0 range add, 1 point set,
//   2 range sum, 3 no-op). Ranges are inclusive and clipped to the array;
//   an empty range sums to 0, a set beyond the array is dropped.
// rsp channel: one beat carrying rsp_range_total for each range sum only.
// Storage is a pair of binary indexed trees in two single-port memories
//   (read data registered); a range sum is the difference of two prefix
//   sums, each prefix walks at most log2(N)+1 nodes.
// A point set reads the element, then adds the difference. One operation
//   is in flight at a time.
// req_ready is high only while the block is idle. A finished sum sits in the
//   rsp output register; the next request is accepted meanwhile, and a later
//   sum waits in its final state until the register is free.
// After reset the memories are swept to zero, one entry per cycle, over all
//   NUM_ELEMENTS+1 entries; no request is accepted during the sweep.
// A stalled receiver only holds rsp_valid and the data; nothing is lost.
`default_nettype none
module lazy_segment_tree_range_add_sum
   import lst_pkg::*;
#(
   parameter int NUM_ELEMENTS = DEF_NUM_ELEMENTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic [POS_W-1:0]         req_range_low,
   input  wire logic [POS_W-1:0]         req_range_high,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_range_total
);

   localparam int AW    = $clog2(NUM_ELEMENTS + 1);
   localparam int XW    = AW + 1;
   localparam int DEPTH = NUM_ELEMENTS + 1;
   localparam logic [XW-1:0] N_X = XW'(NUM_ELEMENTS);

   logic [DATA_W-1:0] mem1 [DEPTH];
   logic [DATA_W-1:0] mem2 [DEPTH];
   logic [DATA_W-1:0] rd1_ff, rd2_ff;
   logic              wr_en, rd_en;
   logic [DATA_W-1:0] wd1, wd2;

   state_type         state_ff, state_in;
   logic [XW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]     l_ff, l_in, r_ff, r_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              set_ff, set_in;
   logic              sec_ff, sec_in;
   logic [DATA_W-1:0] acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] d1_ff, d1_in, d2_ff, d2_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0] lo32, hi32, hic32, mop, mx, pfx, tot;
   logic [XW-1:0]     lowbit;
   logic              empty;

   assign lo32   = DATA_W'(req_range_low);
   assign hi32   = DATA_W'(req_range_high);
   assign hic32  = (hi32 > DATA_W'(NUM_ELEMENTS - 1)) ? DATA_W'(NUM_ELEMENTS - 1) : hi32;
   assign empty  = lo32 > hic32;
   assign lowbit = idx_ff & (-idx_ff);
   assign pfx    = prod_ff - acc2_ff;
   assign tot    = res_ff - pfx;

   always_comb begin
      mop = sec_ff ? -val_ff : val_ff;
      if (state_ff == ST_QMUL) begin
         mop = acc1_ff;
         mx  = DATA_W'(sec_ff ? l_ff - 1'b1 : r_ff);
      end else begin
         mx  = DATA_W'(sec_ff ? r_ff : l_ff - 1'b1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      val_in       = val_ff;
      set_in       = set_ff;
      sec_in       = sec_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wd1          = rd1_ff + d1_ff;
      wd2          = rd2_ff + d2_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wd1   = '0;
            wd2   = '0;
            if (idx_ff == N_X) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in  = DATA_W'(req_value);
               sec_in  = 1'b0;
               acc1_in = '0;
               acc2_in = '0;
               l_in    = XW'(lo32 + 1);
               r_in    = XW'(hic32 + 1);
               set_in  = 1'b0;
               case (req_kind)
                  KIND_ADD: begin
                     if (!empty) state_in = ST_MULA;
                  end
                  KIND_SET: begin
                     if (lo32 < DATA_W'(NUM_ELEMENTS)) begin
                        set_in   = 1'b1;
                        r_in     = XW'(lo32 + 1);
                        idx_in   = XW'(lo32 + 1);
                        state_in = ST_QRD;
                     end
                  end
                  KIND_SUM: begin
                     if (empty) begin
                        res_in   = '0;
                        state_in = ST_OUT;
                     end else begin
                        idx_in   = XW'(hic32 + 1);
                        state_in = ST_QRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_QRD: begin
            if (idx_ff == '0) begin
               state_in = ST_QMUL;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_QACC;
            end
         end
         ST_QACC: begin
            acc1_in  = acc1_ff + rd1_ff;
            acc2_in  = acc2_ff + rd2_ff;
            idx_in   = idx_ff - lowbit;
            state_in = ST_QRD;
         end
         ST_QMUL: begin
            prod_in  = mop * mx;
            state_in = ST_QFIN;
         end
         ST_QFIN: begin
            if (!sec_ff) begin
               res_in   = pfx;
               sec_in   = 1'b1;
               idx_in   = l_ff - 1'b1;
               acc1_in  = '0;
               acc2_in  = '0;
               state_in = ST_QRD;
            end else if (set_ff) begin
               val_in   = val_ff - tot;
               sec_in   = 1'b0;
               state_in = ST_MULA;
            end else begin
               res_in   = tot;
               state_in = ST_OUT;
            end
         end
         ST_MULA: begin
            d1_in    = mop;
            d2_in    = mop * mx;
            idx_in   = sec_ff ? r_ff + 1'b1 : l_ff;
            state_in = ST_URD;
         end
         ST_URD: begin
            if (idx_ff > N_X) begin
               if (!sec_ff) begin
                  sec_in   = 1'b1;
                  state_in = ST_MULA;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ST_UWR;
            end
         end
         ST_UWR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff + lowbit;
            state_in = ST_URD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem1[idx_ff[AW-1:0]] <= wd1;
         mem2[idx_ff[AW-1:0]] <= wd2;
      end
      if (rd_en) begin
         rd1_ff <= mem1[idx_ff[AW-1:0]];
         rd2_ff <= mem2[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      val_ff      <= val_in;
      set_ff      <= set_in;
      sec_ff      <= sec_in;
      acc1_ff     <= acc1_in;
      acc2_ff     <= acc2_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = DATA_W'(rsp_data_ff);

   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during memory sweep");

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UWR || state_ff == ST_CLEAR))
      else $error("memory write outside update or sweep");

   a_upd_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UWR) |-> (idx_ff != '0 && idx_ff <= N_X))
      else $error("update index out of range");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("sum not delivered to output register");

endmodule
`default_nettype wire

[dv/lazy_segment_tree_range_add_sum_test.sv]
`default_nettype none
module lazy_segment_tree_range_add_sum_test;
   import lst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N          = DEF_NUM_ELEMENTS;
   localparam int IDLE_LIMIT = 6000;
   localparam int N_RANDOM   = 550;
   localparam int N_DIRECTED = 21;
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         lo;
      logic [POS_W-1:0]         hi;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      logic signed [DATA_W-1:0] total;
   } op_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind = '0;
   logic [POS_W-1:0]         req_range_low = '0;
   logic [POS_W-1:0]         req_range_high = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_range_total;

   logic [DATA_W-1:0]        element_val [N];
   logic signed [DATA_W-1:0] totals_q [$];
   int                       fails = 0;
   int                       quiet_cycles = 0;
   int                       burst_left = 0;

   lazy_segment_tree_range_add_sum uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] span_total(logic [POS_W-1:0] lo,
                                                    logic [POS_W-1:0] hi);
      logic [DATA_W-1:0] acc;
      acc = '0;
      for (int i = lo; i <= hi && i < N; i++) acc += element_val[i];
      return acc;
   endfunction

   // applies one accepted beat to the shadow array, returns expected total
   function automatic logic [DATA_W-1:0] apply_op(op_row_type r);
      case (r.kind)
         KIND_ADD: for (int i = r.lo; i <= r.hi && i < N; i++) element_val[i] += r.value;
         KIND_SET: if (r.lo < N) element_val[r.lo] = r.value;
         KIND_SUM: return span_total(r.lo, r.hi);
         default: ;
      endcase
      return '0;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
      $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
      fails++;
   endtask

   task automatic send_op(op_row_type r);
      logic [DATA_W-1:0] t;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= r.kind;
      req_range_low <= r.lo;
      req_range_high <= r.hi;
      req_value <= r.value;
      do @(posedge clock); while (!req_ready);
      t = apply_op(r);
      if (r.kind == KIND_SUM) totals_q.push_back(r.typed ? r.total : t);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (totals_q.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_range_total);
         end else begin
            logic signed [DATA_W-1:0] want;
            want = totals_q.pop_front();
            if (rsp_range_total !== want) report_mismatch("range_total", want, rsp_range_total);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern: randomly chosen modes of always-ready, duty cycle, random
   initial begin
      int mode, len;
      forever begin
         mode = $urandom_range(0, 2);
         len = $urandom_range(20, 200);
         for (int c = 0; c < len; c++) begin
            @(negedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= (c % 7) < 3;
               default: rsp_ready <= $urandom_range(0, 3) != 0;
            endcase
         end
      end
   end

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      op_row_type directed [N_DIRECTED] = '{
         '{KIND_SUM, 10'd0,    10'd1023, 32'sd0,        1'b1, 32'sd0},
         '{KIND_SUM, 10'd1023, 10'd1023, 32'sd0,        1'b1, 32'sd0},
         '{KIND_SET, 10'd0,    10'd0,    32'h7fff_ffff, 1'b0, 32'sd0},
         '{KIND_SET, 10'd1023, 10'd0,    32'h8000_0000, 1'b0, 32'sd0},
         '{KIND_SUM, 10'd0,    10'd0,    32'sd0,        1'b1, 32'h7fff_ffff},
         '{KIND_SUM, 10'd1023, 10'd1023, 32'sd0,        1'b1, 32'h8000_0000},
         '{KIND_SUM, 10'd0,    10'd1023, 32'sd0,        1'b1, 32'hffff_ffff},
         '{KIND_SUM, 10'd5,    10'd4,    32'sd0,        1'b1, 32'sd0},
         '{KIND_ADD, 10'd9,    10'd3,    32'sd77,       1'b0, 32'sd0},
         '{KIND_SUM, 10'd0,    10'd1023, 32'sd0,        1'b0, 32'sd0},
         '{KIND_ADD, 10'd0,    10'd1023, 32'sd1,        1'b0, 32'sd0},
         '{KIND_SUM, 10'd0,    10'd1023, 32'sd0,        1'b0, 32'sd0},
         '{KIND_ADD, 10'd100,  10'd611,  32'h8000_0000, 1'b0, 32'sd0},
         '{KIND_ADD, 10'd512,  10'd512,  -32'sd1,       1'b0, 32'sd0},
         '{KIND_NOP, 10'd0,    10'd1023, 32'sd999,      1'b0, 32'sd0},
         '{KIND_SET, 10'd300,  10'd0,    32'sd12345,    1'b0, 32'sd0},
         '{KIND_SUM, 10'd299,  10'd301,  32'sd0,        1'b0, 32'sd0},
         '{KIND_ADD, 10'd256,  10'd767,  32'h7fff_ffff, 1'b0, 32'sd0},
         '{KIND_SUM, 10'd511,  10'd512,  32'sd0,        1'b0, 32'sd0},
         '{KIND_SUM, 10'd1,    10'd1022, 32'sd0,        1'b0, 32'sd0},
         '{KIND_SUM, 10'd0,    10'd1023, 32'sd0,        1'b0, 32'sd0}
      };
      op_row_type r;
      int sel;
      foreach (element_val[i]) element_val[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_op(directed[i]);
      req_valid <= 1'b0;
      wait (totals_q.size() == 0);
      @(negedge clock);
      for (int n = 0; n < N_RANDOM; n++) begin
         r.typed = 1'b0;
         r.total = '0;
         r.value = pick_value();
         sel = $urandom_range(0, 99);
         r.kind = sel < 40 ? KIND_SUM : sel < 65 ? KIND_ADD : sel < 96 ? KIND_SET : KIND_NOP;
         r.lo = POS_W'($urandom);
         r.hi = POS_W'($urandom);
         case ($urandom_range(0, 9))
            0: r.hi = r.lo;
            1: begin r.lo = '0; r.hi = POS_W'(N - 1); end
            2: ;
            default: if (r.lo > r.hi) {r.lo, r.hi} = {r.hi, r.lo};
         endcase
         if (n == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            wait (totals_q.size() == 0);
            @(negedge clock);
         end
         send_op(r);
      end
      req_valid <= 1'b0;
      while (totals_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
